@@ hw/rtl/etd_pkg.sv @@
// ----------------------------------------------------------------------------
// etd_pkg
// Shared widths, codes and divider handshake types for the totient block.
// ----------------------------------------------------------------------------
package etd_pkg;

	localparam int VALUE_BITS   = 31;
	localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);

	// first trial divisor
	localparam logic [VALUE_BITS-1:0] DIVISOR_FIRST = VALUE_BITS'(2);
	localparam logic [VALUE_BITS-1:0] VALUE_ONE     = VALUE_BITS'(1);

	typedef logic [VALUE_BITS-1:0] value_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_STRIP,
		ST_ACC,
		ST_FINAL,
		ST_DONE
	} etd_state_t;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   done;
		value_t quotient;
		value_t remainder;
	} div_rsp_t;

endpackage

@@ hw/rtl/etd_value_if.sv @@
// ----------------------------------------------------------------------------
// etd_value_if
// Valid/ready channel carrying one input number.
// ----------------------------------------------------------------------------
interface etd_value_if;
	import etd_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface

@@ hw/rtl/etd_totient_if.sv @@
// ----------------------------------------------------------------------------
// etd_totient_if
// Valid/ready channel carrying one totient result.
// ----------------------------------------------------------------------------
interface etd_totient_if;
	import etd_pkg::*;

	logic   valid;
	logic   ready;
	value_t totient;

	modport source (output valid, output totient, input ready);
	modport sink   (input valid, input totient, output ready);

endinterface

@@ hw/rtl/etd_divider.sv @@
// ----------------------------------------------------------------------------
// etd_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etd_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  etd_pkg::div_req_t req,
	output etd_pkg::div_rsp_t rsp
);
	import etd_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	value_t                  quo_q;
	value_t                  rem_q;
	value_t                  dsr_q;

	logic [VALUE_BITS:0] shifted;
	logic [VALUE_BITS:0] diff;
	logic                fit;

	assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fit     = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_BITS'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], fit};
			rem_q <= fit ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

@@ hw/rtl/euler_totient_trial_division_top.sv @@
// ----------------------------------------------------------------------------
// euler_totient_trial_division_top
// Euler totient of one unsigned number by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   operand : valid/ready sink, one number per transfer (value).
//   result  : valid/ready source, one totient per transfer (totient).
//   operand.ready is high only while the block is idle; one number is
//   worked on at a time.
// Timing:
//   Every division on the shared divider runs launch, quotient bits, done.
//   A number costs one division per trial divisor tried, one more per
//   stripped prime factor, one per distinct prime factor for the running
//   totient, plus one for a leftover prime. Worst case is a prime near
//   2^31: about 46340 divisions. Best case (0, 1) is a single division;
//   2 and 3 take two.
// Reset:
//   arst_n clears the sequencer to idle; no result is pending afterwards.
// Stall:
//   The finished totient stays in its register with result.valid high
//   until the receiver takes it; no new number is accepted meanwhile.
// ----------------------------------------------------------------------------
module euler_totient_trial_division_top (
	input  logic                 clk,
	input  logic                 arst_n,
	etd_value_if.sink            operand,
	etd_totient_if.source        result
);
	import etd_pkg::*;

	etd_state_t state_q, state_d;

	value_t   rest_q;   // unfactored remainder of the input
	value_t   acc_q;    // running totient
	value_t   d_q;      // current trial divisor
	logic     start_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_xfer;
	logic out_xfer;
	logic past_root;   // d > rest/d : trial loop is over
	logic divides;
	logic launch;

	assign in_xfer   = operand.valid && operand.ready;
	assign out_xfer  = result.valid && result.ready;
	assign past_root = d_q > div_rsp.quotient;
	assign divides   = div_rsp.remainder == '0;

	etd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_TEST;
			end
			ST_TEST: begin
				if (div_rsp.done) begin
					if (past_root) begin
						// leftover above one is the last prime factor
						state_d = (rest_q > VALUE_ONE) ? ST_FINAL : ST_DONE;
					end else if (divides) begin
						state_d = ST_STRIP;
					end
				end
			end
			ST_STRIP: begin
				if (div_rsp.done && !divides) state_d = ST_ACC;
			end
			ST_ACC: begin
				if (div_rsp.done) state_d = ST_TEST;
			end
			ST_FINAL: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_xfer) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and divider operand select
	always_comb begin
		operand.ready    = state_q == ST_IDLE;
		result.valid     = state_q == ST_DONE;
		result.totient   = acc_q;
		launch           = in_xfer || (div_rsp.done && state_d != ST_DONE);
		div_req.start    = start_q;
		div_req.dividend = rest_q;
		div_req.divisor  = d_q;
		unique case (state_q)
			ST_ACC: begin
				div_req.dividend = acc_q;
			end
			ST_FINAL: begin
				div_req.dividend = acc_q;
				div_req.divisor  = rest_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= launch;
		end
	end

	// datapath: operands settle on the same edge that raises start_q
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					rest_q <= operand.value;
					acc_q  <= operand.value;
					d_q    <= DIVISOR_FIRST;
				end
			end
			ST_TEST: begin
				if (div_rsp.done && !past_root) begin
					if (divides) rest_q <= div_rsp.quotient;
					else         d_q    <= d_q + VALUE_ONE;
				end
			end
			ST_STRIP: begin
				if (div_rsp.done && divides) rest_q <= div_rsp.quotient;
			end
			ST_ACC: begin
				if (div_rsp.done) begin
					acc_q <= acc_q - div_rsp.quotient;
					d_q   <= d_q + VALUE_ONE;
				end
			end
			ST_FINAL: begin
				if (div_rsp.done) acc_q <= acc_q - div_rsp.quotient;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// never accept a number while a result is offered
	a_ready_vs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(operand.ready && result.valid))
		else $error("operand.ready and result.valid both high");

	// an accepted number launches the divider at once
	a_launch_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> start_q)
		else $error("no divider launch after input transfer");

	// divider results only arrive while a division is awaited
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q != ST_IDLE && state_q != ST_DONE))
		else $error("divider done outside a compute state");

	// trial divisor never falls below two while factoring
	a_divisor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST || state_q == ST_STRIP || state_q == ST_ACC)
			|-> d_q >= DIVISOR_FIRST)
		else $error("trial divisor below two");
`endif

endmodule

@@ test/euler_totient_trial_division_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_totient_trial_division_top_tb
// Feeds directed and random numbers through the totient block and checks
// every result against a trial-division totient computed in the bench.
// ----------------------------------------------------------------------------
module euler_totient_trial_division_top_tb;
	import etd_pkg::*;

	localparam int     CLK_HALF     = 6;
	localparam int     RESET_CYCLES = 6;
	localparam int     RANDOM_COUNT = 78;
	localparam int     REPORT_MAX   = 10;
	// the result is registered; a short settle window is plenty
	localparam int     SETTLE_CYCLES = 40;
	// a prime near 2^31 costs about 46340 divisions without a single transfer
	localparam int     STALL_LIMIT  = 5_000_000;
	localparam value_t VALUE_MAX    = '1;

	// one pending number; drain_first makes the sender wait until every
	// outstanding totient has come back before offering it
	typedef struct packed {
		logic   drain_first;
		value_t value;
	} operand_item_t;

	logic clk;
	logic arst_n;

	etd_value_if   operand_ch ();
	etd_totient_if result_ch ();

	euler_totient_trial_division_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_ch),
		.result  (result_ch)
	);

	operand_item_t operand_q[$];        // numbers waiting to be offered
	value_t        totient_expect_q[$]; // totients owed by the block, oldest first

	int n_items;
	int n_sent;
	int n_checked;
	int n_holds;
	int n_errors;
	int n_directed;
	int stall_cycles;

	// ------------------------------------------------------------------------
	// Totient by trial division, 64-bit working values so the divisor bound
	// never overflows for any legal input.
	// ------------------------------------------------------------------------
	function automatic value_t totient_of(value_t n);
		longint unsigned acc;
		longint unsigned rest;
		longint unsigned d;
		acc  = n;
		rest = n;
		for (d = DIVISOR_FIRST; d <= rest / d; d++) begin
			if (rest % d == 0) begin
				while (rest % d == 0)
					rest = rest / d;
				acc = acc - acc / d;
			end
		end
		// whatever is left above one is the last prime factor
		if (rest > VALUE_ONE)
			acc = acc - acc / rest;
		return value_t'(acc);
	endfunction

	// Random numbers, mostly cheap: the block's run time grows with the
	// square root of the largest remaining factor.
	function automatic value_t random_operand();
		int unsigned     pick;
		int unsigned     f;
		longint unsigned prod;
		pick = $urandom_range(99);
		if (pick < 55)
			return value_t'($urandom_range(4095));
		if (pick < 70)
			return value_t'($urandom_range(32'h000F_FFFF));
		if (pick < 90) begin
			// smooth numbers spread over the full width, all factors below 62
			prod = 1;
			repeat (40) begin
				f = $urandom_range(61, 2);
				if (prod * f <= VALUE_MAX)
					prod = prod * f;
			end
			return value_t'(prod);
		end
		return value_t'($urandom_range(255, 1)) << $urandom_range(23);
	endfunction

	// idling schedule: sender 30% / receiver 81%, then swapped, then none
	function automatic int idle_phase();
		return (n_sent * 3) / n_items;
	endfunction

	function automatic bit sender_rests();
		case (idle_phase())
			0: return $urandom_range(99) < 30;
			1: return $urandom_range(99) < 81;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_rests();
		case (idle_phase())
			0: return $urandom_range(99) < 81;
			1: return $urandom_range(99) < 30;
			default: return 1'b0;
		endcase
	endfunction

	task automatic note_failure(string msg);
		n_errors++;
		if (n_errors <= REPORT_MAX)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Driver: offers the next pending number once the previous transfer is
	// done. valid stays up until accepted; the value is scrambled while idle.
	// The expected totient is worked out at the transfer itself.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		bit            took;
		bit            launch;
		operand_item_t item;
		if (!arst_n) begin
			operand_ch.valid <= 1'b0;
			operand_ch.value <= '0;
			n_sent           <= 0;
			n_holds          <= 0;
		end else begin
			took = operand_ch.valid && operand_ch.ready;
			if (took) begin
				totient_expect_q.push_back(totient_of(operand_ch.value));
				n_sent <= n_sent + 1;
			end
			if (!operand_ch.valid || took) begin
				launch = operand_q.size() > 0 && !sender_rests();
				// drain point: hold off while any totient is still owed
				if (launch && operand_q[0].drain_first && (n_sent + int'(took) != n_checked))
					launch = 1'b0;
				if (launch) begin
					item = operand_q.pop_front();
					if (item.drain_first)
						n_holds <= n_holds + 1;
					operand_ch.valid <= 1'b1;
					operand_ch.value <= item.value;
				end else begin
					operand_ch.valid <= 1'b0;
					operand_ch.value <= value_t'($urandom);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: random back-pressure on the result channel; every transfer is
	// compared with the oldest owed totient.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		value_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			n_checked       <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				n_checked <= n_checked + 1;
				if (totient_expect_q.size() == 0) begin
					note_failure($sformatf("totient %0d with no number outstanding",
						result_ch.totient));
				end else begin
					want = totient_expect_q.pop_front();
					if (result_ch.totient !== want)
						note_failure($sformatf("totient expected %0d, got %0d",
							want, result_ch.totient));
				end
			end
			result_ch.ready <= !receiver_rests();
		end
	end

	// watchdog: cycles in a row with no transfer on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((operand_ch.valid && operand_ch.ready) ||
				(result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[%0t] timeout: no transfer for %0d cycles, %0d of %0d totients seen",
				$realtime, stall_cycles, n_checked, n_items);
			$display("euler_totient_trial_division_top regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		// zero and one, smallest primes, prime squares right at the divisor
		// bound, powers of two, 46340^2, and the all-ones maximum (a prime,
		// so the divisor sweep runs up to the top of the square range)
		value_t        directed[$] = '{
			0, 1, 2, 3, 4, 6, 9, 12, 30, 49, 97, 100, 128, 210, 1009,
			65536, 1042441, 1073741824, 1073741823, 2147395600,
			2147483646, 2147483647
		};
		operand_item_t item;
		value_t        biggest;
		arst_n   <= 1'b0;
		n_errors = 0;
		biggest  = '0;
		foreach (directed[i]) begin
			item.value       = directed[i];
			item.drain_first = (i == 10);
			operand_q.push_back(item);
		end
		n_directed = operand_q.size();
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			item.value       = random_operand();
			item.drain_first = (i % 30 == 15);
			operand_q.push_back(item);
		end
		foreach (operand_q[i])
			if (operand_q[i].value > biggest)
				biggest = operand_q[i].value;
		n_items = operand_q.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// one totient per number; the watchdog covers a block that hangs
		wait (n_checked == n_items);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (totient_expect_q.size() > 0)
			note_failure($sformatf("totient %0d never delivered",
				totient_expect_q.pop_front()));

		$display("covered %0d numbers (%0d directed, %0d random, largest %0d), %0d drain pauses",
			n_items, n_directed, n_items - n_directed, biggest, n_holds);
		$display("%0d totients compared, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("euler_totient_trial_division_top regression: pass");
		end else begin
			$display("euler_totient_trial_division_top regression: fail");
		end
		$finish;
	end

endmodule
